// ===== rtl/core/gbs_pkg.sv =====
// gbs_pkg: types and constants shared by the greedy box suppression core
// holds the stored box layout, register indexes and reset values
// no dependencies
package gbs_pkg;

    localparam int BOX_W     = 62;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int THR_W     = 16;
    localparam int MAXREP_W  = 7;
    localparam int RANK_W    = 6;
    localparam int SIDE_W    = 15;
    localparam int AREA_W    = 30;
    localparam int UNION_W   = 31;
    localparam int PROD_W    = THR_W + UNION_W;

    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORTED  = 2'd1;

    localparam logic [THR_W-1:0]    IOU_THRESHOLD_RST = 16'd29491;
    localparam logic [MAXREP_W-1:0] MAX_REPORTED_RST  = 7'd5;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [SIDE_W-1:0]  width;
        logic [SIDE_W-1:0]  height;
    } box_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/gbs_ram.sv =====
// gbs_ram: generic single write port, single read port ram
// read data is registered, valid in the cycle after a read with rd_en high
// no dependencies
module gbs_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/greedy_box_suppression_top.sv =====
// greedy_box_suppression_top: greedy iou suppression over a store of kept boxes
// depends on gbs_pkg and gbs_ram
//
// channel   dir  handshake        word
// s_        in   s_valid/s_ready  box_left, box_top, box_width, box_height, frame_end
// m_        out  m_valid/m_ready  kept, kept_rank, reported, store_overflow, frame_done
// cfg_      in   cfg_wr_en        cfg_wr_index, cfg_wr_data
//
// a candidate is taken only in the idle state, so one is handled at a time;
// the one-read-per-cycle scan of the kept box ram feeds the six stage compare
// pipeline, which drains before the result word is set up in the final state
// an empty store skips the scan and goes from idle straight to the final state
// reset restores control, count and config registers; no clearing pass over the ram
// a waiting result holds the core in its final state until m_ready
module greedy_box_suppression_top #(
    parameter int MAX_KEPT = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_box_left,
    input  logic signed [15:0]                  s_box_top,
    input  logic [14:0]                         s_box_width,
    input  logic [14:0]                         s_box_height,
    input  logic                                s_frame_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_kept,
    output logic [5:0]                          m_kept_rank,
    output logic                                m_reported,
    output logic                                m_store_overflow,
    output logic                                m_frame_done,
    input  logic                                cfg_wr_en,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [gbs_pkg::CFG_DAT_W-1:0]       cfg_wr_data
);

    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int PIPE_N = 6;

    function automatic logic [gbs_pkg::SIDE_W-1:0] overlap(
        input logic signed [15:0]          a0,
        input logic [gbs_pkg::SIDE_W-1:0]  aw,
        input logic signed [15:0]          b0,
        input logic [gbs_pkg::SIDE_W-1:0]  bw
    );
        logic signed [16:0] lo;
        logic signed [16:0] ea;
        logic signed [16:0] eb;
        logic signed [16:0] hi;
        logic signed [16:0] d;
        lo = (a0 > b0) ? 17'(a0) : 17'(b0);
        ea = 17'(a0) + $signed({2'b00, aw});
        eb = 17'(b0) + $signed({2'b00, bw});
        hi = (ea < eb) ? ea : eb;
        d  = hi - lo;
        overlap = (hi > lo) ? d[gbs_pkg::SIDE_W-1:0] : '0;
    endfunction

    gbs_pkg::state_t state_reg, state_next;

    logic [gbs_pkg::THR_W-1:0]    iou_threshold_reg;
    logic [gbs_pkg::MAXREP_W-1:0] max_reported_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] scan_idx_reg, scan_idx_next;
    logic              hit_reg;
    logic [PIPE_N-1:0] pv_reg;

    gbs_pkg::box_t               box_reg;
    logic                        frame_end_reg;
    logic [gbs_pkg::AREA_W-1:0]  area_a_reg;

    logic [gbs_pkg::SIDE_W-1:0]  s1_iw_reg, s1_ih_reg, s1_wb_reg, s1_hb_reg;
    logic [gbs_pkg::AREA_W-1:0]  s2_inter_reg;
    logic [gbs_pkg::SIDE_W-1:0]  s2_wb_reg, s2_hb_reg;
    logic [gbs_pkg::AREA_W-1:0]  s3_inter_reg, s3_area_b_reg;
    logic [gbs_pkg::UNION_W-1:0] s4_uni_reg;
    logic [gbs_pkg::AREA_W-1:0]  s4_inter_reg;
    logic [gbs_pkg::PROD_W-1:0]  s5_prod_reg;
    logic [gbs_pkg::AREA_W-1:0]  s5_inter_reg;
    logic                        s4_nz_reg, s5_nz_reg;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_kept_reg, m_reported_reg, m_ovf_reg, m_fdone_reg;
    logic [gbs_pkg::RANK_W-1:0]  m_rank_reg;

    logic                 in_fire;
    logic                 finish;
    logic                 has_room;
    logic                 keep_box;
    logic [CNT_W-1:0]     count_m1;
    logic [ADDR_W-1:0]    last_idx;
    logic [31:0]          count_wide;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [gbs_pkg::BOX_W-1:0] ram_rd_data;
    gbs_pkg::box_t        rd_box;
    logic [31:0]          uni_sum;
    logic                 is_hit;

    assign in_fire    = s_valid && s_ready;
    assign s_ready    = (state_reg == gbs_pkg::ST_IDLE);
    assign finish     = (state_reg == gbs_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign has_room   = (32'(count_reg) < 32'(MAX_KEPT));
    assign keep_box   = !hit_reg;
    assign count_m1   = count_reg - CNT_W'(1);
    assign last_idx   = count_m1[ADDR_W-1:0];
    assign count_wide = 32'(count_reg);
    assign ram_wr_en  = finish && keep_box && has_room;
    assign ram_rd_en  = (state_reg == gbs_pkg::ST_SCAN);
    assign rd_box     = gbs_pkg::box_t'(ram_rd_data);

    gbs_ram #(
        .WIDTH (gbs_pkg::BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (box_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (ram_rd_data)
    );

    // control
    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (state_reg)
            gbs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    scan_idx_next = '0;
                    state_next = (count_reg == '0) ? gbs_pkg::ST_DONE : gbs_pkg::ST_SCAN;
                end
            end
            gbs_pkg::ST_SCAN: begin
                if (scan_idx_reg == last_idx) begin
                    state_next = gbs_pkg::ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                end
            end
            gbs_pkg::ST_DRAIN: begin
                if (pv_reg == '0) begin
                    state_next = gbs_pkg::ST_DONE;
                end
            end
            gbs_pkg::ST_DONE: begin
                if (finish) begin
                    m_valid_next = 1'b1;
                    state_next   = gbs_pkg::ST_IDLE;
                    if (frame_end_reg) begin
                        count_next = '0;
                    end else if (keep_box && has_room) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = gbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= gbs_pkg::ST_IDLE;
            scan_idx_reg      <= '0;
            count_reg         <= '0;
            m_valid_reg       <= 1'b0;
            pv_reg            <= '0;
            hit_reg           <= 1'b0;
            iou_threshold_reg <= gbs_pkg::IOU_THRESHOLD_RST;
            max_reported_reg  <= gbs_pkg::MAX_REPORTED_RST;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            pv_reg       <= {pv_reg[PIPE_N-2:0], ram_rd_en};
            if (in_fire) begin
                hit_reg <= 1'b0;
            end else if (is_hit) begin
                hit_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    gbs_pkg::REG_IOU_THRESHOLD: iou_threshold_reg <= cfg_wr_data;
                    gbs_pkg::REG_MAX_REPORTED:
                        max_reported_reg <= cfg_wr_data[gbs_pkg::MAXREP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // candidate word and compare pipeline
    assign uni_sum = 32'(area_a_reg) + 32'(s3_area_b_reg) - 32'(s3_inter_reg);
    assign is_hit  = pv_reg[5] && s5_nz_reg &&
                     ({1'b0, s5_inter_reg, 16'h0000} > s5_prod_reg);

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            box_reg.left   <= s_box_left;
            box_reg.top    <= s_box_top;
            box_reg.width  <= s_box_width;
            box_reg.height <= s_box_height;
            frame_end_reg  <= s_frame_end;
            area_a_reg     <= s_box_width * s_box_height;
        end
        s1_iw_reg     <= overlap(box_reg.left, box_reg.width, rd_box.left, rd_box.width);
        s1_ih_reg     <= overlap(box_reg.top, box_reg.height, rd_box.top, rd_box.height);
        s1_wb_reg     <= rd_box.width;
        s1_hb_reg     <= rd_box.height;
        s2_inter_reg  <= s1_iw_reg * s1_ih_reg;
        s2_wb_reg     <= s1_wb_reg;
        s2_hb_reg     <= s1_hb_reg;
        s3_area_b_reg <= s2_wb_reg * s2_hb_reg;
        s3_inter_reg  <= s2_inter_reg;
        s4_uni_reg    <= uni_sum[gbs_pkg::UNION_W-1:0];
        s4_nz_reg     <= (uni_sum != 32'd0);
        s4_inter_reg  <= s3_inter_reg;
        s5_prod_reg   <= iou_threshold_reg * s4_uni_reg;
        s5_nz_reg     <= s4_nz_reg;
        s5_inter_reg  <= s4_inter_reg;
    end

    // result word
    always_ff @(posedge aclk) begin
        if (finish) begin
            m_kept_reg     <= keep_box && has_room;
            m_rank_reg     <= (keep_box && has_room) ? count_wide[gbs_pkg::RANK_W-1:0] : '0;
            m_reported_reg <= keep_box && has_room &&
                              (count_wide < 32'(max_reported_reg));
            m_ovf_reg      <= keep_box && !has_room;
            m_fdone_reg    <= frame_end_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kept           = m_kept_reg;
    assign m_kept_rank      = m_rank_reg;
    assign m_reported       = m_reported_reg;
    assign m_store_overflow = m_ovf_reg;
    assign m_frame_done     = m_fdone_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(MAX_KEPT))
        else $error("kept count above store depth");

    a_wr_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == gbs_pkg::ST_DONE) && has_room && !hit_reg)
        else $error("ram write outside the final state");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && frame_end_reg) |=> (count_reg == '0))
        else $error("store not cleared after last box of frame");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_kept && m_store_overflow) && (!m_reported || m_kept))
        else $error("inconsistent result flags");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for greedy_box_suppression_top
// drives candidate boxes and register writes, predicts every result word locally
// depends on gbs_pkg and the core rtl
module tb;

    localparam int MAX_KEPT     = 64;
    localparam int RANDOM_ITEMS = 1880;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 2000000;

    localparam int CFG_IDX_W = gbs_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = gbs_pkg::CFG_DAT_W;
    localparam int THR_W     = gbs_pkg::THR_W;
    localparam int MAXREP_W  = gbs_pkg::MAXREP_W;
    localparam int RANK_W    = gbs_pkg::RANK_W;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {
        FRAME_CLUSTER,
        FRAME_GRID,
        FRAME_NOISE,
        FRAME_EMPTY_BOXES
    } frame_kind_e;

    typedef enum logic {ROW_BOX, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic              kept;
        logic [RANK_W-1:0] rank;
        logic              reported;
        logic              overflow;
        logic              frame_done;
    } outcome_t;

    typedef struct packed {
        row_kind_e            kind;
        gbs_pkg::box_t        box;
        logic                 frame_end;
        logic                 typed;
        outcome_t             want;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [CFG_DAT_W-1:0] cfg_data;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [15:0]   s_box_left = '0;
    logic signed [15:0]   s_box_top = '0;
    logic [14:0]          s_box_width = '0;
    logic [14:0]          s_box_height = '0;
    logic                 s_frame_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_kept;
    logic [5:0]           m_kept_rank;
    logic                 m_reported;
    logic                 m_store_overflow;
    logic                 m_frame_done;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wr_data = '0;

    gbs_pkg::box_t       kept_store [MAX_KEPT];
    int unsigned         kept_total = 0;
    logic [THR_W-1:0]    thr_reg = gbs_pkg::IOU_THRESHOLD_RST;
    logic [MAXREP_W-1:0] maxrep_reg = gbs_pkg::MAX_REPORTED_RST;
    outcome_t            expected_outcomes [$];
    stim_row_t           dir_rows [$];
    int                  mismatch_count = 0;
    int                  items_sent = 0;
    bit                  hold_req = 1'b0;
    bit                  hold_issued = 1'b0;
    bit                  burst_mode = 1'b0;

    greedy_box_suppression_top #(
        .MAX_KEPT(MAX_KEPT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_box_left(s_box_left),
        .s_box_top(s_box_top),
        .s_box_width(s_box_width),
        .s_box_height(s_box_height),
        .s_frame_end(s_frame_end),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kept(m_kept),
        .m_kept_rank(m_kept_rank),
        .m_reported(m_reported),
        .m_store_overflow(m_store_overflow),
        .m_frame_done(m_frame_done),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint span_overlap(longint a0, longint aw, longint b0, longint bw);
        longint lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + aw < b0 + bw) ? a0 + aw : b0 + bw;
        return (hi > lo) ? hi - lo : 64'sd0;
    endfunction

    function automatic bit iou_exceeds(gbs_pkg::box_t a, gbs_pkg::box_t b);
        longint inter, area_a, area_b, uni;
        inter = span_overlap(longint'($signed(a.left)), longint'(a.width),
                             longint'($signed(b.left)), longint'(b.width))
              * span_overlap(longint'($signed(a.top)), longint'(a.height),
                             longint'($signed(b.top)), longint'(b.height));
        area_a = longint'(a.width) * longint'(a.height);
        area_b = longint'(b.width) * longint'(b.height);
        uni = area_a + area_b - inter;
        if (uni == 0)
            return 1'b0;
        return (inter * 65536) > (longint'(thr_reg) * uni);
    endfunction

    function automatic outcome_t predict_outcome(gbs_pkg::box_t b, logic fe);
        outcome_t o;
        bit survives;
        o = '0;
        survives = 1'b1;
        for (int i = 0; i < kept_total; i++) begin
            if (iou_exceeds(b, kept_store[i])) begin
                survives = 1'b0;
                break;
            end
        end
        if (survives) begin
            if (kept_total < MAX_KEPT) begin
                kept_store[kept_total] = b;
                o.kept = 1'b1;
                o.rank = kept_total[RANK_W-1:0];
                o.reported = (kept_total < maxrep_reg);
                kept_total++;
            end else begin
                o.overflow = 1'b1;
            end
        end
        if (fe)
            kept_total = 0;
        o.frame_done = fe;
        return o;
    endfunction

    function automatic gbs_pkg::box_t make_box(int l, int t, int w, int h);
        gbs_pkg::box_t b;
        b.left = 16'(l);
        b.top = 16'(t);
        b.width = 15'(w);
        b.height = 15'(h);
        return b;
    endfunction

    function automatic stim_row_t row_box(int l, int t, int w, int h, logic fe);
        stim_row_t r;
        r = '0;
        r.kind = ROW_BOX;
        r.box = make_box(l, t, w, h);
        r.frame_end = fe;
        return r;
    endfunction

    function automatic stim_row_t row_typed(int l, int t, int w, int h, logic fe,
                                           logic k, int rank, logic rep);
        stim_row_t r;
        r = row_box(l, t, w, h, fe);
        r.typed = 1'b1;
        r.want.kept = k;
        r.want.rank = RANK_W'(rank);
        r.want.reported = rep;
        r.want.overflow = 1'b0;
        r.want.frame_done = fe;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_data = data;
        return r;
    endfunction

    function automatic void add_row(stim_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_box(gbs_pkg::box_t b, logic fe, int gap, bit typed, outcome_t want);
        outcome_t pred;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_box_left <= b.left;
        s_box_top <= b.top;
        s_box_width <= b.width;
        s_box_height <= b.height;
        s_frame_end <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = predict_outcome(b, fe);
        expected_outcomes.insert(expected_outcomes.size(), typed ? want : pred);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gbs_pkg::REG_IOU_THRESHOLD: thr_reg = data;
            gbs_pkg::REG_MAX_REPORTED:  maxrep_reg = data[MAXREP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reconfigure();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: cfg_write(gbs_pkg::REG_IOU_THRESHOLD, '0);
            1: cfg_write(gbs_pkg::REG_IOU_THRESHOLD, '1);
            2, 3: cfg_write(gbs_pkg::REG_IOU_THRESHOLD,
                            CFG_DAT_W'($urandom_range(0, 65535)));
            4: cfg_write(gbs_pkg::REG_IOU_THRESHOLD,
                         CFG_DAT_W'($urandom_range(16384, 49152)));
            5: cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         CFG_DAT_W'($urandom_range(0, 65535)));
            default: ;
        endcase
        pick = $urandom_range(0, 5);
        case (pick)
            0: cfg_write(gbs_pkg::REG_MAX_REPORTED, '0);
            1: cfg_write(gbs_pkg::REG_MAX_REPORTED, CFG_DAT_W'(64));
            2, 3: cfg_write(gbs_pkg::REG_MAX_REPORTED, CFG_DAT_W'($urandom_range(0, 64)));
            default: ;
        endcase
    endtask

    task automatic send_frame();
        frame_kind_e   kind;
        int            n, pick, nc, k, col, row, base_x, base_y;
        int            cx [3];
        int            cy [3];
        int            cs [3];
        gbs_pkg::box_t b;
        logic          fe;
        pick = $urandom_range(0, 19);
        kind = (pick < 11) ? FRAME_CLUSTER : (pick < 15) ? FRAME_GRID :
               (pick < 18) ? FRAME_NOISE : FRAME_EMPTY_BOXES;
        burst_mode = ($urandom_range(0, 3) == 0);
        case (kind)
            FRAME_CLUSTER: n = $urandom_range(1, 24);
            FRAME_GRID:    n = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 72)
                                                           : $urandom_range(4, 30);
            FRAME_NOISE:   n = $urandom_range(1, 8);
            default:       n = $urandom_range(1, 10);
        endcase
        // long receiver hold while this frame keeps offering boxes
        if (!hold_issued && items_sent >= HOLD_AT) begin
            hold_issued = 1'b1;
            hold_req <= 1'b1;
            burst_mode = 1'b1;
            kind = FRAME_GRID;
            n = 40;
        end
        nc = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) begin
            cx[i] = int'($urandom_range(0, 40000)) - 20000;
            cy[i] = int'($urandom_range(0, 40000)) - 20000;
            cs[i] = $urandom_range(64, 2048);
        end
        base_x = int'($urandom_range(0, 50000)) - 30000;
        base_y = int'($urandom_range(0, 50000)) - 30000;
        b = '0;
        for (int j = 0; j < n; j++) begin
            fe = (j == n - 1);
            case (kind)
                FRAME_CLUSTER: begin
                    k = $urandom_range(0, nc - 1);
                    b = make_box(cx[k] + int'($urandom_range(0, cs[k] / 2)) - cs[k] / 4,
                                 cy[k] + int'($urandom_range(0, cs[k] / 2)) - cs[k] / 4,
                                 cs[k] - cs[k] / 4 + int'($urandom_range(0, cs[k] / 2)),
                                 cs[k] - cs[k] / 4 + int'($urandom_range(0, cs[k] / 2)));
                end
                FRAME_GRID: begin
                    // disjoint cells, with an occasional repeat of the last box
                    if (j == 0 || $urandom_range(0, 5) != 0) begin
                        col = j % 9;
                        row = j / 9;
                        b = make_box(base_x + col * 512 + int'($urandom_range(0, 16)),
                                     base_y + row * 512 + int'($urandom_range(0, 16)),
                                     $urandom_range(16, 480), $urandom_range(16, 480));
                    end
                end
                FRAME_NOISE: begin
                    b.left = 16'($urandom);
                    b.top = 16'($urandom);
                    b.width = 15'($urandom);
                    b.height = 15'($urandom);
                    fe = fe || ($urandom_range(0, 4) == 0);
                end
                default: begin
                    b = make_box($urandom_range(0, 1024), $urandom_range(0, 1024),
                                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 512),
                                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 512));
                end
            endcase
            send_box(b, fe, pick_gap(), 1'b0, '0);
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result word with no prediction waiting", $time);
                mismatch_count++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("kept", 8'(want.kept), 8'(m_kept));
                check_field("kept_rank", 8'(want.rank), 8'(m_kept_rank));
                check_field("reported", 8'(want.reported), 8'(m_reported));
                check_field("store_overflow", 8'(want.overflow), 8'(m_store_overflow));
                check_field("frame_done", 8'(want.frame_done), 8'(m_frame_done));
            end
        end
    end

    initial begin : result_sink
        int stall, phase_left, r;
        bit sink_burst;
        stall = 0;
        phase_left = 0;
        sink_burst = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (phase_left == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 300);
            end else begin
                phase_left--;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!sink_burst && r < 25)
                    stall = $urandom_range(1, 3);
                else if (!sink_burst && r < 28)
                    stall = $urandom_range(20, 60);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int random_goal;
        // after reset, extremes, empty and touching boxes
        add_row(row_typed(0, 0, 256, 256, 1'b0, 1'b1, 0, 1'b1));
        add_row(row_typed(0, 0, 256, 256, 1'b0, 1'b0, 0, 1'b0));
        add_row(row_typed(-32768, -32768, 32767, 32767, 1'b0, 1'b1, 1, 1'b1));
        add_row(row_typed(32767, 32767, 32767, 32767, 1'b0, 1'b1, 2, 1'b1));
        add_row(row_typed(0, 0, 0, 256, 1'b0, 1'b1, 3, 1'b1));
        add_row(row_typed(0, 0, 0, 0, 1'b0, 1'b1, 4, 1'b1));
        add_row(row_typed(256, 0, 256, 256, 1'b0, 1'b1, 5, 1'b0));
        add_row(row_box(128, 0, 256, 256, 1'b0));
        add_row(row_box(64, 0, 256, 256, 1'b0));
        add_row(row_typed(0, 0, 256, 256, 1'b1, 1'b0, 0, 1'b0));
        add_row(row_typed(0, 0, 256, 256, 1'b0, 1'b1, 0, 1'b1));
        // zero threshold: any overlap suppresses
        add_row(row_cfg(gbs_pkg::REG_IOU_THRESHOLD, '0));
        add_row(row_typed(255, 255, 256, 256, 1'b0, 1'b0, 0, 1'b0));
        add_row(row_typed(256, 256, 256, 256, 1'b0, 1'b1, 1, 1'b1));
        // top threshold: an identical box suppresses, one a row smaller does not
        add_row(row_cfg(gbs_pkg::REG_IOU_THRESHOLD, '1));
        add_row(row_typed(0, 0, 256, 256, 1'b0, 1'b0, 0, 1'b0));
        add_row(row_box(0, 0, 256, 255, 1'b0));
        add_row(row_cfg(gbs_pkg::REG_MAX_REPORTED, '0));
        add_row(row_typed(1024, 1024, 16, 16, 1'b0, 1'b1, 3, 1'b0));
        add_row(row_cfg(gbs_pkg::REG_MAX_REPORTED, CFG_DAT_W'(64)));
        add_row(row_typed(2048, 2048, 16, 16, 1'b1, 1'b1, 4, 1'b1));
        add_row(row_cfg(REG_SPARE_2, '1));
        add_row(row_cfg(REG_SPARE_3, 16'h5a5a));
        add_row(row_typed(0, 0, 32767, 32767, 1'b1, 1'b1, 0, 1'b1));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG)
                cfg_write(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            else
                send_box(dir_rows[i].box, dir_rows[i].frame_end, pick_gap(),
                         dir_rows[i].typed, dir_rows[i].want);
        end

        cfg_write(gbs_pkg::REG_IOU_THRESHOLD, gbs_pkg::IOU_THRESHOLD_RST);
        cfg_write(gbs_pkg::REG_MAX_REPORTED, CFG_DAT_W'(gbs_pkg::MAX_REPORTED_RST));
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if ($urandom_range(0, 11) == 0)
                reconfigure();
            send_frame();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
